/* src/acpf_pkg.sv */
`default_nettype none
package acpf_pkg;

	localparam int MAX_PAYLOAD = 58;
	localparam int FRAME_WORDS = 7;

	localparam logic [7:0]  PRE0       = 8'h55;
	localparam logic [7:0]  PRE1       = 8'hAA;
	localparam logic [4:0]  CRC5_INIT  = 5'h1F;
	localparam logic [4:0]  CRC5_POLY  = 5'h05;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam int          JOB_BIT    = 5;

	typedef struct packed {
		logic       first;
		logic [7:0] hdr;
		logic [5:0] plen;
		logic [7:0] data;
	} acpf_item_t;

	typedef struct packed {
		logic [4:0]  crc5;
		logic [15:0] crc16;
		logic        job;
		logic [5:0]  left;
	} acpf_state_t;

	typedef struct packed {
		logic [FRAME_WORDS-1:0][7:0] bytes;
		logic [2:0]                  cnt;
		logic                        eof;
	} acpf_frame_t;

	// MSB-first CRC-5, x^5+x^2+1
	function automatic logic [4:0] crc5_byte(input logic [4:0] c, input logic [7:0] b);
		logic [4:0] r;
		logic       fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[4] ^ b[i];
			r  = {r[3:0], 1'b0};
			if (fb) begin
				r = r ^ CRC5_POLY;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC16_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/acpf_build.sv */
`default_nettype none
module acpf_build
	import acpf_pkg::*;
(
	input  wire acpf_item_t  item,
	input  wire acpf_state_t cur,
	output acpf_frame_t      frm,
	output acpf_state_t      nxt
);

	logic [5:0]  plen_c;
	logic [7:0]  lenb;
	logic        job_n;
	logic        active;
	logic [4:0]  c5;
	logic [15:0] c16;
	logic [5:0]  left_n;

	always_comb begin
		// zero length taken as one, oversize clamped
		if (item.plen == 6'd0) begin
			plen_c = 6'd1;
		end else if (item.plen > 6'(MAX_PAYLOAD)) begin
			plen_c = 6'(MAX_PAYLOAD);
		end else begin
			plen_c = item.plen;
		end
		job_n = item.first ? item.hdr[JOB_BIT] : cur.job;
		lenb  = {2'b00, plen_c} + (item.hdr[JOB_BIT] ? 8'd4 : 8'd3);

		frm    = '0;
		nxt    = cur;
		active = item.first || (cur.left != 6'd0);

		if (item.first) begin
			c5  = crc5_byte(crc5_byte(crc5_byte(CRC5_INIT, item.hdr), lenb), item.data);
			c16 = crc16_byte(crc16_byte(crc16_byte(CRC16_INIT, item.hdr), lenb), item.data);
			left_n = plen_c - 6'd1;
		end else begin
			c5  = crc5_byte(cur.crc5, item.data);
			c16 = crc16_byte(cur.crc16, item.data);
			left_n = cur.left - 6'd1;
		end

		if (active) begin
			nxt.crc5  = c5;
			nxt.crc16 = c16;
			nxt.job   = job_n;
			nxt.left  = left_n;
			if (item.first) begin
				frm.bytes[0] = PRE0;
				frm.bytes[1] = PRE1;
				frm.bytes[2] = item.hdr;
				frm.bytes[3] = lenb;
				frm.bytes[4] = item.data;
				frm.cnt      = 3'd5;
				if (left_n == 6'd0) begin
					frm.eof = 1'b1;
					if (job_n) begin
						frm.bytes[5] = c16[15:8];
						frm.bytes[6] = c16[7:0];
						frm.cnt      = 3'd7;
					end else begin
						frm.bytes[5] = {3'b000, c5};
						frm.cnt      = 3'd6;
					end
				end
			end else begin
				frm.bytes[0] = item.data;
				frm.cnt      = 3'd1;
				if (left_n == 6'd0) begin
					frm.eof = 1'b1;
					if (job_n) begin
						frm.bytes[1] = c16[15:8];
						frm.bytes[2] = c16[7:0];
						frm.cnt      = 3'd3;
					end else begin
						frm.bytes[1] = {3'b000, c5};
						frm.cnt      = 3'd2;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/acpf_out_buf.sv */
`default_nettype none
module acpf_out_buf
	import acpf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         load,
	input  wire acpf_frame_t frm,
	output logic        load_ok,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // frame_byte
	output logic        m_tlast    // end_of_frame
);

	logic [FRAME_WORDS-1:0][7:0] bytes_q;
	logic [2:0]                  cnt_q;
	logic [2:0]                  idx_q;
	logic                        eof_q;
	logic                        at_last;
	logic                        xfer;

	assign at_last  = (idx_q == cnt_q - 3'd1);
	assign xfer     = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = bytes_q[idx_q];
	assign m_tlast  = eof_q && at_last;
	// refill as the final word leaves, so words run back to back
	assign load_ok  = !m_tvalid || (xfer && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
			eof_q <= 1'b0;
		end else if (load) begin
			cnt_q <= frm.cnt;
			idx_q <= 3'd0;
			eof_q <= frm.eof;
		end else if (xfer) begin
			if (at_last) begin
				cnt_q <= 3'd0;
				idx_q <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= frm.bytes;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 3'd0) |-> (idx_q < cnt_q))
		else $error("word index past frame count");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && at_last && !load) |=> !m_tvalid)
		else $error("buffer still valid after last word");

endmodule
`default_nettype wire

/* src/asic_chain_packet_framer.sv */
// Packet framer for a chained serial link.
// Slave stream: one payload byte per word. s_tuser high marks the first payload
// byte of a packet; that word also carries the header byte and payload length.
// Master stream: the framed bytes 0x55, 0xAA, header, length, payload, then a
// CRC-5 byte (command packets) or CRC-16 high/low bytes (job packets, header
// bit 5). m_tlast is high on the final check byte.
// A word accepted into the input register is framed when the output buffer is
// free and is loaded into that buffer; its first output byte is then valid there.
// Throughput: the master side moves one byte per cycle while m_tready is high; a
// word that opens a packet makes 5 to 7 bytes and a later word 1 to 3, and a word
// with no packet open makes none. The output buffer refills in the same cycle its last
// byte leaves, so bytes run back to back under a constant tready.
// Reset clears both CRCs to their init values and closes any open packet.
// When the receiver stalls, the output buffer holds its byte, one more input
// word waits in the input register, and s_tready drops.
`default_nettype none
module asic_chain_packet_framer
	import acpf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // header_byte[7:0], payload_len[13:8], data_byte[21:14], zero
	input  wire         s_tuser,   // first_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // frame_byte[7:0]
	output logic        m_tlast    // end_of_frame
);

	acpf_item_t  item_s1;
	logic        valid_s1;
	acpf_state_t st_q;
	acpf_state_t st_nxt;
	acpf_frame_t frm;
	logic        load_ok;
	logic        take;

	assign take     = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.first <= s_tuser;
			item_s1.hdr   <= s_tdata[7:0];
			item_s1.plen  <= s_tdata[13:8];
			item_s1.data  <= s_tdata[21:14];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.crc5  <= CRC5_INIT;
			st_q.crc16 <= CRC16_INIT;
			st_q.job   <= 1'b0;
			st_q.left  <= 6'd0;
		end else if (take) begin
			st_q <= st_nxt;
		end
	end

	acpf_build u_build (
		.item (item_s1),
		.cur  (st_q),
		.frm  (frm),
		.nxt  (st_nxt)
	);

	acpf_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.frm      (frm),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.left <= 6'(MAX_PAYLOAD - 1))
		else $error("bytes-left counter out of range");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> valid_s1)
		else $error("input word dropped before framing");

endmodule
`default_nettype wire
